### sv/sle_pkg.sv
// Shared types and constants for the sprite line evaluation block.
// No dependencies; imported by sle_attr_mem and sprite_line_evaluation_core.
`default_nettype none

package sle_pkg;

   // Scan sizing
   localparam int ENTRY_COUNT  = 64;
   localparam int MAX_PER_LINE = 8;
   localparam int RESULT_LIMIT = 8;
   localparam int SEL_CAP      = (MAX_PER_LINE < RESULT_LIMIT) ? MAX_PER_LINE : RESULT_LIMIT;

   // Attribute memory geometry: 256 bytes as 64 rows of one four-byte entry
   localparam int MEM_BYTES       = 256;
   localparam int BYTES_PER_ENTRY = 4;
   localparam int ROW_COUNT       = MEM_BYTES / BYTES_PER_ENTRY;
   localparam int ROW_W           = $clog2(ROW_COUNT);
   localparam int LANE_W          = $clog2(BYTES_PER_ENTRY);
   localparam int WORD_W          = 8 * BYTES_PER_ENTRY;

   localparam int IDX_W = $clog2(ENTRY_COUNT + 1);
   localparam int CNT_W = $clog2(SEL_CAP + 1);

   localparam logic [7:0] TOP_LIMIT    = 8'hEF;
   localparam logic [8:0] HEIGHT_TALL  = 9'd16;
   localparam logic [8:0] HEIGHT_SHORT = 9'd8;

   // Transaction kinds
   localparam logic [1:0] KIND_SET_PTR = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_EVAL    = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] cur_line;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] sprite_x;
      logic [7:0] sprite_top;
      logic [7:0] sprite_attr;
      logic [7:0] sprite_tile;
      logic       entry_zero;
      logic       last;
   } rsp_type;

   // Memory byte write port
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } sle_wr_type;

   // Memory row read port
   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
   } sle_rd_type;

endpackage

`default_nettype wire

### sv/sle_attr_mem.sv
// Sprite attribute memory: byte-write, row-read synchronous RAM with a registered read.
// Rows never written since reset read as zero. Depends on sle_pkg.
`default_nettype none

module sle_attr_mem
   import sle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sle_wr_type        wr,
   input  wire sle_rd_type        rd,
   output      logic [WORD_W-1:0] rd_word
);

   logic [WORD_W-1:0]          mem [ROW_COUNT];
   logic [ROW_COUNT-1:0]       row_valid_ff;
   logic [WORD_W-1:0]          rd_data_ff;
   logic                       rd_valid_ff;

   logic [ROW_W-1:0]           wr_row;
   logic [LANE_W-1:0]          wr_lane;
   logic [BYTES_PER_ENTRY-1:0] wr_be;
   logic [WORD_W-1:0]          wr_word;

   assign wr_row  = wr.addr[7:LANE_W];
   assign wr_lane = wr.addr[LANE_W-1:0];

   // First write to a row fills the other lanes with zero
   always_comb begin
      wr_word = '0;
      wr_word[wr_lane*8 +: 8] = wr.data;
      if (row_valid_ff[wr_row]) begin
         wr_be = '0;
         wr_be[wr_lane] = 1'b1;
      end else begin
         wr_be = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int i = 0; i < BYTES_PER_ENTRY; i++) begin
            if (wr_be[i]) begin
               mem[wr_row][i*8 +: 8] <= wr_word[i*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= row_valid_ff[rd.row];
         end
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

`ifndef SYNTHESIS
   // Single port in practice: the core never reads and writes together
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr.en && rd.en))
      else $error("attribute memory read and write in the same cycle");

   // A written row stays valid until reset
   a_row_stays_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> row_valid_ff[$past(wr_row)])
      else $error("row valid flag lost after write");

   // Read data of an unwritten row is forced to zero
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      !rd_valid_ff |-> (rd_word == '0))
      else $error("unwritten row read as nonzero");
`endif

endmodule

`default_nettype wire

### sv/sprite_line_evaluation_core.sv
// Sprite line evaluation core: attribute memory, pointer and line scan sequencer.
// Depends on sle_pkg and sle_attr_mem.
//
// Usage:
//  - req channel (valid/ready) carries one transaction per item: set the byte
//    pointer, write one byte at the pointer and advance it (wraps at 255), or
//    evaluate the line after req_data.cur_line. An unused kind is dropped.
//  - rsp channel (valid/ready) returns one transaction per selected sprite, in
//    memory order, the final one flagged by last; with no match a single
//    not-found transaction (found = 0, last = 1) is sent.
//  - csr_write_enable/csr_write_data set the 8x16 sprite mode; write only idle.
// Timing:
//  - Pointer and byte writes keep req_ready high.
//  - Evaluation reads one four-byte entry per cycle from the attribute RAM
//    while rsp does not stall; the eighth match ends the scan early. A
//    match is emitted when the next one is found or the scan ends, so
//    last is known when a transaction is presented.
//  - rsp has a one-deep output register: a new request is taken while the
//    final result still waits. If rsp stalls mid-scan, the scan holds.
// Reset: pointer and mode clear; the RAM reads as zero through per-row valid
//  flags, so no clearing pass is needed and requests are taken at once.
`default_nettype none

module sprite_line_evaluation_core
   import sle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [7:0]       ptr_ff, ptr_in;
   logic             tall_ff;
   logic [8:0]       line_ff, line_in;
   logic [IDX_W-1:0] idx_ff, idx_in;       // next entry to read
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in; // entry whose data sits at the RAM output
   logic             ev_valid_ff, ev_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_type          pend_ff, pend_in;     // newest match, held until its last flag is known
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   sle_wr_type       mem_wr;
   sle_rd_type       mem_rd;
   logic [WORD_W-1:0] entry_word;

   logic       req_fire;
   logic       out_free;
   logic [7:0] ent_y, ent_tile, ent_attr, ent_x, ent_top;
   logic [8:0] top_ext, height;
   logic       match;
   logic       ev_go, hit_cap, scan_done_idx;
   rsp_type    match_rsp, not_found_rsp;

   sle_attr_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_word (entry_word)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Entry layout: y, tile, attributes, x
   assign ent_y    = entry_word[7:0];
   assign ent_tile = entry_word[15:8];
   assign ent_attr = entry_word[23:16];
   assign ent_x    = entry_word[31:24];
   assign ent_top  = ent_y + 8'd1;
   assign top_ext  = {1'b0, ent_top};
   assign height   = tall_ff ? HEIGHT_TALL : HEIGHT_SHORT;

   // Tops past the visible area never match
   assign match = ev_valid_ff && (ent_top <= TOP_LIMIT)
                  && (line_ff >= top_ext) && (line_ff < (top_ext + height));

   always_comb begin
      match_rsp             = '0;
      match_rsp.found       = 1'b1;
      match_rsp.sprite_x    = ent_x;
      match_rsp.sprite_top  = ent_top;
      match_rsp.sprite_attr = ent_attr;
      match_rsp.sprite_tile = ent_tile;
      match_rsp.entry_zero  = (ev_idx_ff == '0);
      not_found_rsp         = '0;
      not_found_rsp.last    = 1'b1;
   end

   // Hold the entry in the RAM output while an earlier match cannot move out
   assign ev_go         = ev_valid_ff && !(match && pend_valid_ff && !out_free);
   assign hit_cap       = ev_go && match && (cnt_ff == CNT_W'(SEL_CAP - 1));
   assign scan_done_idx = (idx_ff == IDX_W'(ENTRY_COUNT));

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      line_in       = line_ff;
      idx_in        = idx_ff;
      ev_idx_in     = ev_idx_ff;
      ev_valid_in   = ev_valid_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_wr        = '0;
      mem_rd        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.kind)
                  KIND_SET_PTR: begin
                     ptr_in = req_data.data_byte;
                  end
                  KIND_WRITE: begin
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = ptr_ff;
                     mem_wr.data = req_data.data_byte;
                     ptr_in      = ptr_ff + 8'd1;
                  end
                  KIND_EVAL: begin
                     line_in     = {1'b0, req_data.cur_line} + 9'd1;
                     idx_in      = '0;
                     cnt_in      = '0;
                     ev_valid_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (ev_go && match) begin
               if (pend_valid_ff) begin
                  rsp_in       = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in       = match_rsp;
               pend_valid_in = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            if ((!ev_valid_ff || ev_go) && (hit_cap || scan_done_idx)) begin
               ev_valid_in = 1'b0;
               state_in    = ST_FLUSH;
            end else if (!ev_valid_ff || ev_go) begin
               mem_rd.en   = 1'b1;
               mem_rd.row  = ROW_W'(idx_ff);
               ev_idx_in   = idx_ff;
               ev_valid_in = 1'b1;
               idx_in      = idx_ff + IDX_W'(1);
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = not_found_rsp;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         tall_ff       <= 1'b0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         if (csr_write_enable) begin
            tall_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff   <= line_in;
      ev_idx_ff <= ev_idx_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   // No match is left pending between evaluations
   a_pend_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending match outside of an evaluation");

   // Match count never passes the per-line cap
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SEL_CAP))
      else $error("match count above cap");

   // Entry data in flight only while scanning
   a_ev_in_scan: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> (state_ff == ST_SCAN))
      else $error("entry stage valid outside scan");

   // Leaving flush always presents a final transaction
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("evaluation ended without a last transaction");

   // Mid-scan pushes are never flagged last
   a_scan_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && rsp_valid_in && !(rsp_valid_ff && !rsp_ready))
      |=> !rsp_ff.last)
      else $error("last flag set before the scan ended");
`endif

endmodule

`default_nettype wire
